// ===== hdl/hrcr_pkg.sv =====
package hrcr_pkg;

	// Table geometry
	localparam int ENTRIES = 256;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FILL_W  = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ENTRIES - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(ENTRIES);

	// Hash
	localparam int HASH_W = 32;
	localparam logic [HASH_W-1:0] HASH_INIT = 32'd5381;
	localparam int HASH_SHIFT = 5;

	// Payload widths
	localparam int BYTE_W = 8;
	localparam int PRIO_W = 3;
	localparam int SLOT_W = 8;

	// First characters that allow local handling
	localparam logic [BYTE_W-1:0] CHAR_I = 8'h69;
	localparam logic [BYTE_W-1:0] CHAR_H = 8'h68;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_PRIO  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_PRIO = 1'd1;
	localparam logic [PRIO_W-1:0] LOW_PRIO_RST  = 3'd3;
	localparam logic [PRIO_W-1:0] CRIT_PRIO_RST = 3'd0;

	typedef enum logic [1:0] {
		ACT_ROUTE  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		RT_CACHE    = 2'd0,
		RT_REJECT   = 2'd1,
		RT_LOCAL    = 2'd2,
		RT_EXTERNAL = 2'd3
	} route_t;

	// Write side of the tag table
	typedef struct packed {
		logic              ins;
		logic              clr;
		logic [IDX_W-1:0]  waddr;
		logic [HASH_W-1:0] wdata;
	} tbl_cmd_t;

	// Outcome of one table search
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             rej_found;
		logic [IDX_W-1:0] rej_idx;
	} scan_res_t;

endpackage

// ===== hdl/hrcr_ram.sv =====
module hrcr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/hrcr_hash.sv =====
module hrcr_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          restart,
	input  logic                          has_byte,
	input  logic [hrcr_pkg::BYTE_W-1:0]   key_byte,
	input  logic                          last,
	output logic [hrcr_pkg::HASH_W-1:0]   key_hash,
	output logic [hrcr_pkg::BYTE_W-1:0]   first_char
);

	import hrcr_pkg::*;

	logic [HASH_W-1:0] hash_q;
	logic [BYTE_W-1:0] first_q;
	logic              start_q;
	logic [HASH_W-1:0] folded;

	// hash * 33 + byte, wrapping
	assign folded = {hash_q[HASH_W-HASH_SHIFT-1:0], HASH_SHIFT'(0)} + hash_q
	              + HASH_W'(key_byte);
	assign key_hash = has_byte ? folded : hash_q;
	assign first_char = start_q ? (has_byte ? key_byte : '0) : first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= HASH_INIT;
			first_q <= '0;
			start_q <= 1'b1;
		end else if (restart || (en && last)) begin
			hash_q  <= HASH_INIT;
			first_q <= '0;
			start_q <= 1'b1;
		end else if (en && has_byte) begin
			hash_q <= folded;
			if (start_q) begin
				first_q <= key_byte;
				start_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/hrcr_table.sv =====
module hrcr_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hrcr_pkg::tbl_cmd_t           cmd,
	input  logic                         rd_en,
	input  logic [hrcr_pkg::IDX_W-1:0]   rd_addr,
	output logic [hrcr_pkg::HASH_W-1:0]  rd_tag,
	output logic                         rd_valid
);

	import hrcr_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic               valid_s1;
	logic [HASH_W-1:0]  ram_rdata;

	hrcr_ram #(
		.WIDTH(HASH_W),
		.DEPTH(ENTRIES)
	) u_tags (
		.clk  (clk),
		.we   (cmd.ins),
		.waddr(cmd.waddr),
		.wdata(cmd.wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// An entry never written since reset or clear reads as a zero tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd.clr) begin
				valid_q <= '0;
			end else if (cmd.ins) begin
				valid_q[cmd.waddr] <= 1'b1;
			end
			if (rd_en) begin
				valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_valid = valid_s1;
	assign rd_tag   = valid_s1 ? ram_rdata : '0;

endmodule

// ===== hdl/hrcr_scan.sv =====
module hrcr_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [hrcr_pkg::HASH_W-1:0]   key_hash,
	input  logic [hrcr_pkg::FILL_W-1:0]   fill_count,
	output logic                          rd_en,
	output logic [hrcr_pkg::IDX_W-1:0]    rd_addr,
	input  logic [hrcr_pkg::HASH_W-1:0]   rd_tag,
	input  logic                          rd_valid,
	output logic                          busy,
	output logic                          done,
	output hrcr_pkg::scan_res_t           res
);

	import hrcr_pkg::*;

	logic             busy_q;
	logic             issue_q;
	logic [IDX_W-1:0] addr_q;
	logic             chk_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             last_s1;
	logic             rej_found_q;
	logic [IDX_W-1:0] rej_idx_q;
	logic             done_q;
	scan_res_t        res_q;

	logic tag_eq;
	logic vmatch;
	logic rmatch;
	logic scan_stop;

	// The one comparator, reused for every entry
	assign tag_eq = (rd_tag == key_hash);
	assign vmatch = chk_s1 && rd_valid && tag_eq;
	assign rmatch = chk_s1 && tag_eq && ({1'b0, idx_s1} < FILL_W'(fill_count));

	// Stop on the first valid match or after the last entry
	assign scan_stop = chk_s1 && (vmatch || last_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			issue_q     <= 1'b0;
			addr_q      <= '0;
			chk_s1      <= 1'b0;
			idx_s1      <= '0;
			last_s1     <= 1'b0;
			rej_found_q <= 1'b0;
			rej_idx_q   <= '0;
			done_q      <= 1'b0;
			res_q       <= '0;
		end else begin
			done_q <= !start && scan_stop;
			if (start) begin
				busy_q      <= 1'b1;
				issue_q     <= 1'b1;
				addr_q      <= '0;
				chk_s1      <= 1'b0;
				rej_found_q <= 1'b0;
			end else begin
				chk_s1  <= issue_q && !scan_stop;
				idx_s1  <= addr_q;
				last_s1 <= (addr_q == LAST_IDX);
				if (rmatch && !rej_found_q) begin
					rej_found_q <= 1'b1;
					rej_idx_q   <= idx_s1;
				end
				if (scan_stop) begin
					busy_q          <= 1'b0;
					issue_q         <= 1'b0;
					res_q.hit       <= vmatch;
					res_q.hit_idx   <= idx_s1;
					res_q.rej_found <= rej_found_q || rmatch;
					res_q.rej_idx   <= rej_found_q ? rej_idx_q : idx_s1;
				end else if (issue_q) begin
					if (addr_q == LAST_IDX) begin
						issue_q <= 1'b0;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
			end
		end
	end

	assign rd_en   = issue_q;
	assign rd_addr = addr_q;
	assign busy    = busy_q;
	assign done    = done_q;
	assign res     = res_q;

endmodule

// ===== hdl/hashed_request_cache_router.sv =====
// Request cache router. Key strings arrive one byte per item and are folded
// into a 32-bit djb2 hash (hash * 33 + byte). The last item of a key decides
// what happens: an insert key writes its hash into the tag table at a
// wrapping FIFO pointer and returns the slot it used; a route key searches
// the table and returns cache (lowest valid entry with the same tag), reject
// (no valid match, priority at or above low_priority_level, and a tag match
// among the first fill-count entries, valid or not), local (priority equal to
// critical_priority_level and a key starting with 'i' or 'h') or external.
// A clear item drops every tag and valid mark and any partial key, but keeps
// the fill count and the write pointer; it gives no result.
// Sequence: a byte item that does not end a key only folds into the hash. The
// end of an insert key goes through the result state to the output register.
// The end of a route key walks the tag memory through one read port, one entry
// per cycle, with a single shared 32-bit comparator, and ends early at the
// first valid match. No item is accepted during the walk. A finished result
// waits in the output register while the next key's bytes are taken.
module hashed_request_cache_router (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input items
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,  // key_byte[7:0], priority_req[10:8]
	input  logic [2:0]                       s_tuser,  // action[1:0], has_byte[2]
	input  logic                             s_tlast,
	// Result items
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [47:0]                      m_tdata,  // route[1:0], hit[2], slot[10:3],
	                                                   // key_hash[42:11]
	// Configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hrcr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hrcr_pkg::PRIO_W-1:0]      cfg_data
);

	import hrcr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	state_t state_q;

	// Configuration
	logic [PRIO_W-1:0] low_prio_q;
	logic [PRIO_W-1:0] crit_prio_q;

	// Table bookkeeping
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  wptr_q;

	// Key captured at its last item, and the result waiting for the output
	logic [HASH_W-1:0] key_hash_q;
	logic [BYTE_W-1:0] first_char_q;
	logic [PRIO_W-1:0] prio_q;
	route_t            res_route_q;
	logic              res_hit_q;
	logic [SLOT_W-1:0] res_slot_q;

	// Output register
	logic              m_tvalid_q;
	route_t            out_route_q;
	logic              out_hit_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [HASH_W-1:0] out_hash_q;

	// Unpacked input fields
	action_t           act;
	logic              has_byte;
	logic [BYTE_W-1:0] key_byte;
	logic [PRIO_W-1:0] prio_in;

	logic in_accept;
	logic key_item;
	logic key_end;
	logic clr_item;

	logic [HASH_W-1:0] key_hash_nx;
	logic [BYTE_W-1:0] first_char_nx;

	tbl_cmd_t          tbl_cmd;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [HASH_W-1:0] rd_tag;
	logic              rd_valid;
	logic              scan_start;
	logic              scan_busy;
	logic              scan_done;
	scan_res_t         scan_res;
	logic              out_free;

	assign act      = action_t'(s_tuser[1:0]);
	assign has_byte = s_tuser[2];
	assign key_byte = s_tdata[7:0];
	assign prio_in  = s_tdata[10:8];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign key_item  = in_accept && ((act == ACT_ROUTE) || (act == ACT_INSERT));
	assign key_end   = key_item && s_tlast;
	assign clr_item  = in_accept && (act == ACT_CLEAR);

	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	hrcr_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (key_item),
		.restart   (clr_item),
		.has_byte  (has_byte),
		.key_byte  (key_byte),
		.last      (s_tlast),
		.key_hash  (key_hash_nx),
		.first_char(first_char_nx)
	);

	// Write side of the table: insert at the FIFO pointer, clear drops all
	always_comb begin
		tbl_cmd.ins   = key_end && (act == ACT_INSERT);
		tbl_cmd.clr   = clr_item;
		tbl_cmd.waddr = wptr_q;
		tbl_cmd.wdata = key_hash_nx;
	end

	assign scan_start = key_end && (act == ACT_ROUTE);

	hrcr_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (tbl_cmd),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_tag  (rd_tag),
		.rd_valid(rd_valid)
	);

	hrcr_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.key_hash  (key_hash_q),
		.fill_count(fill_q),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_tag    (rd_tag),
		.rd_valid  (rd_valid),
		.busy      (scan_busy),
		.done      (scan_done),
		.res       (scan_res)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_prio_q  <= LOW_PRIO_RST;
			crit_prio_q <= CRIT_PRIO_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOW_PRIO:  low_prio_q  <= cfg_data;
				REG_CRIT_PRIO: crit_prio_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Fill count saturates at the table size; the write pointer wraps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			wptr_q <= '0;
		end else if (tbl_cmd.ins) begin
			if (fill_q != FILL_FULL) begin
				fill_q <= fill_q + 1'b1;
			end
			wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + 1'b1;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			key_hash_q   <= '0;
			first_char_q <= '0;
			prio_q       <= '0;
			res_route_q  <= RT_CACHE;
			res_hit_q    <= 1'b0;
			res_slot_q   <= '0;
			m_tvalid_q   <= 1'b0;
			out_route_q  <= RT_CACHE;
			out_hit_q    <= 1'b0;
			out_slot_q   <= '0;
			out_hash_q   <= '0;
		end else begin
			// Show a finished result; drop the shown item once taken
			if ((state_q == ST_RESULT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (key_end) begin
						key_hash_q   <= key_hash_nx;
						first_char_q <= first_char_nx;
						prio_q       <= prio_in;
						if (act == ACT_INSERT) begin
							res_route_q <= RT_CACHE;
							res_hit_q   <= 1'b0;
							res_slot_q  <= SLOT_W'(wptr_q);
							state_q     <= ST_RESULT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						res_hit_q <= scan_res.hit;
						if (scan_res.hit) begin
							res_route_q <= RT_CACHE;
							res_slot_q  <= SLOT_W'(scan_res.hit_idx);
						end else if ((prio_q >= low_prio_q) && scan_res.rej_found) begin
							res_route_q <= RT_REJECT;
							res_slot_q  <= SLOT_W'(scan_res.rej_idx);
						end else if ((prio_q == crit_prio_q) &&
						             ((first_char_q == CHAR_I) || (first_char_q == CHAR_H))) begin
							res_route_q <= RT_LOCAL;
							res_slot_q  <= '0;
						end else begin
							res_route_q <= RT_EXTERNAL;
							res_slot_q  <= '0;
						end
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					// Hold until the output register is free, then advance
					if (out_free) begin
						out_route_q <= res_route_q;
						out_hit_q   <= res_hit_q;
						out_slot_q  <= res_slot_q;
						out_hash_q  <= key_hash_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_hash_q, out_slot_q, out_hit_q, out_route_q};

	// The walk never overlaps an accepted item
	a_scan_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		scan_busy |-> !s_tready)
		else $error("input accepted during table walk");

	// A finished walk only lands in the walk state
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (state_q == ST_SCAN))
		else $error("walk finished outside walk state");

	// Fill count stays within the table
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill count beyond table size");

	// A hit is only reported with the cache route
	a_hit_is_cache: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_hit_q) |-> (out_route_q == RT_CACHE))
		else $error("hit reported with a non-cache route");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import hrcr_pkg::*;

	// Spacing after the last result before a register write or the end of the run:
	// a route scan of the whole table plus margin.
	localparam int SETTLE_CYCLES = ENTRIES + 44;
	// Cycles in a row without any handshake on input, output or configuration before the run is declared hung.
	localparam int QUIET_LIMIT = 20 * (ENTRIES + 4);
	localparam int POOL_DEPTH = 64;

	// One result item, with the fields that the block packs on m_tdata
	typedef struct packed {
		route_t            route;
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [HASH_W-1:0] key_hash;
	} route_item_t;

	// A key string of up to eight bytes; b[0] goes out first
	typedef struct packed {
		logic [3:0]             len;
		logic [7:0][BYTE_W-1:0] b;
	} key_t;

	// Shadow of the router: tag memory, valid marks, FIFO pointer and the
	// key being hashed, plus the queue of routes still owed by the block.
	class route_scoreboard;
		logic [HASH_W-1:0] tags[ENTRIES];
		bit                valid[ENTRIES];
		int unsigned       fill;
		int unsigned       wr_ptr;
		logic [HASH_W-1:0] hash;
		logic [BYTE_W-1:0] first_byte;
		bit                key_empty;
		logic [PRIO_W-1:0] low_lvl;
		logic [PRIO_W-1:0] crit_lvl;
		route_item_t       pending[$];
		int                mismatches;
		int                route_count[4];
		int                inserts;
		int                clears;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				tags[i] = '0;
				valid[i] = 1'b0;
			end
			fill = 0;
			wr_ptr = 0;
			low_lvl = LOW_PRIO_RST;
			crit_lvl = CRIT_PRIO_RST;
			mismatches = 0;
			inserts = 0;
			clears = 0;
			for (int i = 0; i < 4; i++)
				route_count[i] = 0;
			restart_key();
		endfunction

		function void restart_key();
			hash = HASH_INIT;
			first_byte = '0;
			key_empty = 1'b1;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PRIO_W-1:0] val);
			if (idx == REG_LOW_PRIO)
				low_lvl = val;
			else if (idx == REG_CRIT_PRIO)
				crit_lvl = val;
		endfunction

		// Fold one accepted input item; queue a route when it closes a key.
		function void note_item(action_t act, logic hb, logic [BYTE_W-1:0] kb, logic lst,
				logic [PRIO_W-1:0] pr);
			route_item_t res;
			logic [BYTE_W-1:0] fc;
			bit found;
			if (act == ACT_NONE)
				return;
			if (act == ACT_CLEAR) begin
				// Tags and marks go, fill count and pointer stay, partial key is dropped
				for (int i = 0; i < ENTRIES; i++) begin
					tags[i] = '0;
					valid[i] = 1'b0;
				end
				clears++;
				restart_key();
				return;
			end
			// Bytes fold whatever their action; only the closing item's action counts
			if (hb) begin
				if (key_empty) begin
					first_byte = kb;
					key_empty = 1'b0;
				end
				hash = (hash << HASH_SHIFT) + hash + {{(HASH_W-BYTE_W){1'b0}}, kb};
			end
			if (!lst)
				return;
			res.key_hash = hash;
			fc = key_empty ? '0 : first_byte;
			restart_key();
			res.route = RT_CACHE;
			res.hit = 1'b0;
			res.slot = '0;
			if (act == ACT_INSERT) begin
				res.slot = SLOT_W'(wr_ptr);
				tags[wr_ptr] = res.key_hash;
				valid[wr_ptr] = 1'b1;
				wr_ptr = (wr_ptr + 1) % ENTRIES;
				if (fill < ENTRIES)
					fill++;
				inserts++;
			end else begin
				found = 1'b0;
				for (int i = 0; i < ENTRIES && !found; i++) begin
					if (valid[i] && tags[i] == res.key_hash) begin
						found = 1'b1;
						res.slot = SLOT_W'(i);
					end
				end
				if (found) begin
					res.hit = 1'b1;
				end else begin
					// Duplicate check ignores valid marks but stops at the fill count
					if (pr >= low_lvl) begin
						for (int i = 0; i < int'(fill) && !found; i++) begin
							if (tags[i] == res.key_hash) begin
								found = 1'b1;
								res.slot = SLOT_W'(i);
							end
						end
					end
					if (found)
						res.route = RT_REJECT;
					else if (pr == crit_lvl && (fc == CHAR_I || fc == CHAR_H))
						res.route = RT_LOCAL;
					else
						res.route = RT_EXTERNAL;
				end
				route_count[res.route]++;
			end
			pending.push_back(res);
		endfunction

		task report(string msg);
			if (mismatches < 100)
				$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		// Compare one accepted result with the oldest route still owed.
		task check_result(route_item_t got);
			route_item_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result route %0d hash %h", got.route,
					got.key_hash));
				return;
			end
			want = pending.pop_front();
			if (got.route !== want.route)
				report($sformatf("route %0d, want %0d (hash %h)", got.route, want.route,
					want.key_hash));
			if (got.hit !== want.hit)
				report($sformatf("hit %b, want %b (hash %h)", got.hit, want.hit,
					want.key_hash));
			if (got.slot !== want.slot)
				report($sformatf("slot %0d, want %0d (hash %h)", got.slot, want.slot,
					want.key_hash));
			if (got.key_hash !== want.key_hash)
				report($sformatf("key_hash %h, want %h", got.key_hash, want.key_hash));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;   // key_byte[7:0], priority_req[10:8]
	logic [2:0]           s_tuser = '0;   // action[1:0], has_byte[2]
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [47:0]          m_tdata;        // route[1:0], hit[2], slot[10:3], key_hash[42:11]
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PRIO_W-1:0]    cfg_data = '0;

	route_scoreboard sb = new();
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   items_sent = 0;
	int   quiet_cycles = 0;
	key_t key_pool[POOL_DEPTH];
	int   pool_fill = 0;
	int   pool_next = 0;

	hashed_request_cache_router DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Receiver: stall at random per cycle at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Observe every handshake at the edge it completes: feed the shadow model with
	// accepted input items and register writes, check accepted results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				sb.note_item(action_t'(s_tuser[1:0]), s_tuser[2], s_tdata[7:0], s_tlast,
					s_tdata[10:8]);
			if (m_tvalid && m_tready)
				sb.check_result(route_item_t'({route_t'(m_tdata[1:0]), m_tdata[2],
					m_tdata[10:3], m_tdata[42:11]}));
		end
	end

	// Watchdog: a hung handshake anywhere shows up as a long quiet stretch.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles, %0d routes owed", quiet_cycles,
				sb.pending.size());
			$display("hashed_request_cache_router regression: fail");
			$finish;
		end
	end

	// Offer one input item after a random gap and hold it until accepted. Leave
	// tvalid high on return so back-to-back items keep the bus busy.
	task automatic send_item(action_t act, logic hb, logic [BYTE_W-1:0] kb, logic lst,
			logic [PRIO_W-1:0] pr);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, pr, kb};
		s_tuser <= {hb, act};
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		if (act != ACT_NONE)
			items_sent++;
	endtask

	// Send a whole key. With noise, mix actions on the inner bytes and slip in
	// empty items, ignored items and the odd clear that abandons the key.
	task automatic send_key(key_t k, action_t act, logic [PRIO_W-1:0] pr, bit noisy);
		int n;
		int r;
		n = int'(k.len);
		if (n == 0) begin
			send_item(act, 1'b0, BYTE_W'($urandom), 1'b1, pr);
			return;
		end
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 2) == 0) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					send_item(ACT_CLEAR, 1'($urandom), BYTE_W'($urandom), 1'($urandom),
						PRIO_W'($urandom));
				else if (r < 5)
					send_item(ACT_NONE, 1'($urandom), BYTE_W'($urandom), 1'($urandom),
						PRIO_W'($urandom));
				else
					send_item(action_t'($urandom_range(0, 1)), 1'b0, BYTE_W'($urandom),
						1'b0, PRIO_W'($urandom));
			end
			if (i == n - 1)
				send_item(act, 1'b1, k.b[i], 1'b1, pr);
			else
				send_item(noisy ? action_t'($urandom_range(0, 1)) : act, 1'b1, k.b[i],
					1'b0, PRIO_W'($urandom));
		end
	endtask

	// Write both priority levels back to back; valid stays high across the pair.
	task automatic set_levels(logic [PRIO_W-1:0] low, logic [PRIO_W-1:0] crit);
		cfg_valid <= 1'b1;
		cfg_index <= REG_LOW_PRIO;
		cfg_data <= low;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_CRIT_PRIO;
		cfg_data <= crit;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Drop tvalid, wait out every owed route, then leave the block idle for a
	// margin before it is touched again.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic key_t random_key(bit local_lead);
		key_t k;
		k = '0;
		k.len = local_lead ? 4'($urandom_range(1, 4)) : 4'($urandom_range(0, 4));
		for (int i = 0; i < 8; i++)
			k.b[i] = BYTE_W'($urandom);
		if (local_lead)
			k.b[0] = $urandom_range(0, 1) ? CHAR_I : CHAR_H;
		return k;
	endfunction

	// Eight-byte key whose hash wraps to zero: the only hash a cleared tag can
	// match, so the only way to reach a reject. Write the residue that cancels
	// the seed, plus a random multiple of 2^32, in base 33; every digit is a byte.
	function automatic key_t zero_hash_key();
		key_t k;
		logic [HASH_W-1:0] scaled;
		longint unsigned digits;
		k = '0;
		scaled = HASH_INIT;
		repeat (8) scaled = (scaled << HASH_SHIFT) + scaled;
		scaled = -scaled;
		digits = {32'd0, scaled} + 64'($urandom_range(0, 300)) * 64'h1_0000_0000;
		for (int i = 7; i >= 0; i--) begin
			k.b[i] = BYTE_W'(digits % 33);
			digits = digits / 33;
		end
		k.len = 4'd8;
		return k;
	endfunction

	// Random traffic: mostly well-formed insert and route keys, with route keys
	// drawn to hit the cache, trigger rejects and qualify for local handling;
	// a sprinkle of clears, ignored items and full drains in between.
	task automatic run_traffic(int target);
		key_t k;
		int pick;
		logic [PRIO_W-1:0] pr;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				send_item(ACT_CLEAR, 1'($urandom), BYTE_W'($urandom), 1'($urandom),
					PRIO_W'($urandom));
			end else if (pick < 4) begin
				// Hold off until the block has returned everything owed
				s_tvalid <= 1'b0;
				do @(posedge clk); while (sb.pending.size() != 0);
			end else if (pick < 6) begin
				send_item(ACT_NONE, 1'($urandom), BYTE_W'($urandom), 1'($urandom),
					PRIO_W'($urandom));
			end else if (pick < 50) begin
				k = ($urandom_range(0, 19) == 0) ? zero_hash_key() :
					random_key($urandom_range(0, 3) == 0);
				send_key(k, ACT_INSERT, PRIO_W'($urandom), $urandom_range(0, 9) == 0);
				key_pool[pool_next] = k;
				pool_next = (pool_next + 1) % POOL_DEPTH;
				if (pool_fill < POOL_DEPTH)
					pool_fill++;
			end else begin
				pick = $urandom_range(0, 99);
				pr = PRIO_W'($urandom);
				if (pick < 40 && pool_fill > 0) begin
					k = key_pool[$urandom_range(0, pool_fill - 1)];
				end else if (pick < 55) begin
					k = zero_hash_key();
				end else if (pick < 75) begin
					k = random_key(1'b1);
					if ($urandom_range(0, 3) != 0)
						pr = sb.crit_lvl;
				end else begin
					k = random_key(1'b0);
				end
				send_key(k, ACT_ROUTE, pr, $urandom_range(0, 9) == 0);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// Directed: reset levels written explicitly, then the corner cases
		set_levels(LOW_PRIO_RST, CRIT_PRIO_RST);
		send_item(ACT_ROUTE, 1'b0, 8'h00, 1'b1, 3'd0);    // empty key: external
		send_item(ACT_ROUTE, 1'b1, CHAR_I, 1'b1, 3'd0);   // local on 'i'
		send_item(ACT_ROUTE, 1'b1, CHAR_H, 1'b1, 3'd0);   // local on 'h'
		send_item(ACT_INSERT, 1'b0, 8'hFF, 1'b1, 3'd7);   // empty key into slot 0
		send_item(ACT_ROUTE, 1'b0, 8'hFF, 1'b1, 3'd7);    // cache hit on slot 0
		send_item(ACT_ROUTE, 1'b1, 8'h00, 1'b1, 3'd7);    // zero byte folds, no match
		send_item(ACT_CLEAR, 1'b1, 8'hFF, 1'b1, 3'd7);
		send_item(ACT_ROUTE, 1'b0, 8'h00, 1'b1, 3'd7);    // cleared table: external
		send_key(zero_hash_key(), ACT_ROUTE, 3'd7, 1'b0); // stale zero tag: reject
		send_item(ACT_ROUTE, 1'b1, 8'h61, 1'b0, 3'd0);    // mixed actions, insert wins
		send_item(ACT_INSERT, 1'b1, 8'hFF, 1'b1, 3'd5);
		send_item(ACT_NONE, 1'b1, 8'hFF, 1'b1, 3'd7);     // ignored
		send_item(ACT_ROUTE, 1'b1, 8'h78, 1'b0, 3'd0);    // partial key abandoned
		send_item(ACT_CLEAR, 1'b0, 8'h00, 1'b0, 3'd0);
		send_item(ACT_ROUTE, 1'b1, CHAR_I, 1'b1, 3'd0);
		send_item(ACT_ROUTE, 1'b0, 8'h00, 1'b0, 3'd0);    // empty item before first byte
		send_item(ACT_ROUTE, 1'b1, CHAR_H, 1'b1, 3'd0);

		// Random phases, each with its own level settings and idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: begin
					set_levels(3'd0, 3'd7);
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					set_levels(3'd7, 3'd0);
					send_idle_pct = 67;
					recv_stall_pct = 0;
				end
				2: begin
					set_levels(PRIO_W'($urandom), PRIO_W'($urandom));
					send_idle_pct = 0;
					recv_stall_pct = 67;
				end
				default: begin
					set_levels(PRIO_W'($urandom_range(0, 3)), PRIO_W'($urandom));
					send_idle_pct = 31;
					recv_stall_pct = 31;
				end
			endcase
			run_traffic(items_sent + 500);
		end

		settle();
		$display("covered %0d items: %0d inserts, %0d clears; routes cache %0d, reject %0d,",
			items_sent, sb.inserts, sb.clears, sb.route_count[RT_CACHE],
			sb.route_count[RT_REJECT]);
		$display("  local %0d, external %0d over five level settings and four idle patterns",
			sb.route_count[RT_LOCAL], sb.route_count[RT_EXTERNAL]);
		if (sb.mismatches == 0)
			$display("hashed_request_cache_router regression: pass");
		else
			$display("hashed_request_cache_router regression: fail");
		$finish;
	end

endmodule
